FILE: hdl/lsfs_pkg.sv
package lsfs_pkg;

  // Field and state widths.
  localparam int OP_W      = 2;
  localparam int INDEX_W   = 8;
  localparam int COLOUR_W  = 24;
  localparam int COUNT_W   = 9;
  localparam int WORD_W    = 32;
  localparam int BITCNT_W  = $clog2(WORD_W);

  // Default number of entries in the colour store.
  localparam int LED_MAX_DEFAULT = 256;

  // Depth of the request queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Frame words.
  localparam logic [WORD_W-1:0]   HEADER_WORD = 32'hFF00_0000;
  localparam logic [WORD_W-1:0]   END_WORD    = 32'hFFFF_FFFF;
  localparam logic [BITCNT_W-1:0] BIT_LAST    = BITCNT_W'(WORD_W - 1);

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Serializer phase.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_LEDS  = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    op_t                 op;
    logic                set_ok;
    logic [INDEX_W-1:0]  idx;
    logic [COLOUR_W-1:0] colour;
  } cmd_t;

endpackage

FILE: hdl/led_strip_frame_serializer_top.sv
// Serial LED strip frame serializer. Colours are written into a store of LED_MAX
// 24-bit entries (cleared by reset and by a clear request), and a start request
// begins an update that then sends one serial bit per tick request: 32 zero bits,
// one 32-bit frame per LED (header 0xFF, then colour high, middle and low bytes,
// MSB first), then 32 one bits. Set, clear and start requests are ignored while an
// update is busy. Every request returns exactly one result. A request passes a
// two-entry queue and is executed by the back end, so a steady stream runs at one
// request per cycle while its results are taken; a tick that ends the start frame or
// an LED frame and moves on to another LED frame holds off the next request, because
// that frame comes from the store's registered read port.
module led_strip_frame_serializer_top #(
  parameter int LED_MAX = lsfs_pkg::LED_MAX_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lsfs_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lsfs_pkg::OP_W-1:0]     op,
  input  logic [lsfs_pkg::INDEX_W-1:0]  led_index,
  input  logic [lsfs_pkg::COLOUR_W-1:0] colour,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          data_bit,
  output logic                          bit_valid,
  output logic                          last,
  output logic                          busy_res
);
  import lsfs_pkg::*;

  logic [COUNT_W-1:0] led_count;
  logic [COUNT_W-1:0] eff_count;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;

  // LED count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= '0;
    end else if (cfg_we) begin
      led_count <= cfg_wdata;
    end
  end

  // A count above the store size acts as the store size.
  assign eff_count = (32'(led_count) > LED_MAX) ? COUNT_W'(LED_MAX) : led_count;

  lsfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .led_index (led_index),
    .colour    (colour),
    .eff_count (eff_count),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  lsfs_back #(
    .LED_MAX (LED_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_count (eff_count),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_bit  (data_bit),
    .bit_valid (bit_valid),
    .last      (last),
    .busy_res  (busy_res)
  );

endmodule

FILE: hdl/lsfs_front.sv
module lsfs_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lsfs_pkg::OP_W-1:0]        op,
  input  logic [lsfs_pkg::INDEX_W-1:0]     led_index,
  input  logic [lsfs_pkg::COLOUR_W-1:0]    colour,
  input  logic [lsfs_pkg::COUNT_W-1:0]     eff_count,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output lsfs_pkg::cmd_t                   cmd
);
  import lsfs_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  cmd_t              cls;
  logic              push;
  logic              pop;

  // Classify the incoming request; the range check of a set is done here.
  always_comb begin
    cls.op     = op_t'(op);
    cls.set_ok = ({1'b0, led_index} < eff_count);
    cls.idx    = led_index;
    cls.colour = colour;
  end

  assign in_ready  = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("request queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |=> !($past(pop)) || (count != '0) || $past(push))
    else $error("request queue popped while empty");

endmodule

FILE: hdl/lsfs_back.sv
module lsfs_back #(
  parameter int LED_MAX = lsfs_pkg::LED_MAX_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lsfs_pkg::COUNT_W-1:0] eff_count,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  lsfs_pkg::cmd_t               cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         data_bit,
  output logic                         bit_valid,
  output logic                         last,
  output logic                         busy_res
);
  import lsfs_pkg::*;

  localparam int AW = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;

  // Colour store with one valid bit per entry; an invalid entry reads as zero.
  logic [COLOUR_W-1:0] store [LED_MAX];
  logic [LED_MAX-1:0]  store_vld;
  logic [COLOUR_W-1:0] rd_data;
  logic                rd_vld;

  phase_t              phase, phase_next;
  logic [COUNT_W-1:0]  pointer, pointer_next;
  logic [BITCNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [WORD_W-1:0]   shift_word, shift_word_next;
  logic                load_pending, load_pending_next;

  logic                pop;
  logic                idle;
  logic [COUNT_W-1:0]  ptr_inc;
  logic [COUNT_W-1:0]  rd_ptr;
  logic [AW+COUNT_W-1:0] rd_ext;
  logic [AW+INDEX_W-1:0] wr_ext;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_en;
  logic                clr_en;
  logic                res_dbit;
  logic                res_valid;
  logic                res_last;

  assign cmd_ready = !load_pending && (!out_valid || out_ready);
  assign pop       = cmd_valid && cmd_ready;
  assign idle      = (phase == PH_IDLE);
  assign ptr_inc   = pointer + 1'b1;

  assign rd_ext  = {AW'(0), rd_ptr};
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_ext  = {AW'(0), cmd.idx};
  assign wr_addr = wr_ext[AW-1:0];

  // Request execution and serializer sequencing.
  always_comb begin
    phase_next        = phase;
    pointer_next      = pointer;
    bit_cnt_next      = bit_cnt;
    shift_word_next   = shift_word;
    load_pending_next = load_pending;
    rd_ptr            = '0;
    wr_en             = 1'b0;
    clr_en            = 1'b0;
    res_dbit          = 1'b0;
    res_valid         = 1'b0;
    res_last          = 1'b0;

    if (load_pending) begin
      // The next LED frame arrives from the store's registered read port in the cycle after its read.
      shift_word_next   = HEADER_WORD | {8'h00, (rd_vld ? rd_data : '0)};
      load_pending_next = 1'b0;
    end else if (pop) begin
      unique case (cmd.op)
        OP_TICK: begin
          if (!idle) begin
            res_dbit        = shift_word[WORD_W-1];
            res_valid       = 1'b1;
            shift_word_next = {shift_word[WORD_W-2:0], 1'b0};
            if (bit_cnt == BIT_LAST) begin
              bit_cnt_next = '0;
              unique case (phase)
                PH_START: begin
                  pointer_next = '0;
                  if (eff_count != '0) begin
                    phase_next        = PH_LEDS;
                    rd_ptr            = '0;
                    load_pending_next = 1'b1;
                  end else begin
                    phase_next      = PH_END;
                    shift_word_next = END_WORD;
                  end
                end
                PH_LEDS: begin
                  pointer_next = ptr_inc;
                  if (ptr_inc < eff_count) begin
                    rd_ptr            = ptr_inc;
                    load_pending_next = 1'b1;
                  end else begin
                    phase_next      = PH_END;
                    shift_word_next = END_WORD;
                  end
                end
                PH_END: begin
                  phase_next      = PH_IDLE;
                  shift_word_next = '0;
                  pointer_next    = '0;
                  res_last        = 1'b1;
                end
                default: begin
                  phase_next = phase;
                end
              endcase
            end else begin
              bit_cnt_next = bit_cnt + 1'b1;
            end
          end
        end
        OP_SET: begin
          wr_en = idle && cmd.set_ok;
        end
        OP_CLEAR: begin
          clr_en = idle;
        end
        OP_START: begin
          if (idle) begin
            phase_next      = PH_START;
            pointer_next    = '0;
            bit_cnt_next    = '0;
            shift_word_next = '0;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Serializer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pointer      <= '0;
      bit_cnt      <= '0;
      shift_word   <= '0;
      load_pending <= 1'b0;
    end else begin
      phase        <= phase_next;
      pointer      <= pointer_next;
      bit_cnt      <= bit_cnt_next;
      shift_word   <= shift_word_next;
      load_pending <= load_pending_next;
    end
  end

  // Store data array with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= cmd.colour;
    end
    rd_data <= store[rd_addr];
    rd_vld  <= store_vld[rd_addr];
  end

  // Per-entry valid bits; reset and clear requests empty the store at once.
  always_ff @(posedge clk) begin
    if (rst || clr_en) begin
      store_vld <= '0;
    end else if (wr_en) begin
      store_vld[wr_addr] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_bit  <= res_dbit;
      bit_valid <= res_valid;
      last      <= res_last;
      busy_res  <= (phase_next != PH_IDLE);
    end
  end

  a_load_in_leds: assert property (@(posedge clk) disable iff (rst)
    load_pending |-> (phase == PH_LEDS))
    else $error("frame load pending outside the LED frames");

  a_last_ends_update: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (bit_valid && !busy_res))
    else $error("final bit reported while the update continues");

  a_load_blocks_pop: assert property (@(posedge clk) disable iff (rst)
    $past(pop) && load_pending |-> !pop)
    else $error("request taken while a frame load is pending");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import lsfs_pkg::*;

  localparam int STRIP_LEDS   = LED_MAX_DEFAULT;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_COUNT = -1;
  localparam int PLAN_LEN     = 6;

  // One result as the block returns it.
  typedef struct packed {
    logic data_bit;
    logic bit_valid;
    logic last;
    logic busy_res;
  } strip_result_t;

  // One row of the directed table; typed rows carry their own answer.
  typedef struct packed {
    op_t                 op;
    logic [INDEX_W-1:0]  idx;
    logic [COLOUR_W-1:0] col;
    logic                typed;
    strip_result_t       res;
  } directed_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op        = '0;
  logic [INDEX_W-1:0]  led_index = '0;
  logic [COLOUR_W-1:0] colour    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                data_bit;
  logic                bit_valid;
  logic                last;
  logic                busy_res;

  // Shadow copy of the serializer state.
  logic [COLOUR_W-1:0] store_m [STRIP_LEDS];
  phase_t              phase_m;
  logic [COUNT_W-1:0]  ptr_m;
  logic [BITCNT_W-1:0] bitcnt_m;
  logic [WORD_W-1:0]   shift_m;
  logic [COUNT_W-1:0]  led_count_m;

  strip_result_t serial_q [$];

  int errors       = 0;
  int cycles       = 0;
  int req_total    = 0;
  int bits_seen    = 0;
  int updates_done = 0;
  int settings     = 0;
  int send_idle    = 0;
  int recv_stall   = 0;

  directed_row_t directed_rows [0:12] = '{
    '{OP_TICK,  8'h00, 24'h000000, 1'b1, 4'b0000},
    '{OP_TICK,  8'hFF, 24'hFFFFFF, 1'b1, 4'b0000},
    '{OP_SET,   8'h00, 24'hFFFFFF, 1'b1, 4'b0000},
    '{OP_SET,   8'hFF, 24'h000000, 1'b1, 4'b0000},
    '{OP_CLEAR, 8'h00, 24'h000000, 1'b1, 4'b0000},
    '{OP_START, 8'h00, 24'h000000, 1'b1, 4'b0001},
    '{OP_SET,   8'h00, 24'hFFFFFF, 1'b1, 4'b0001},
    '{OP_CLEAR, 8'hFF, 24'hFFFFFF, 1'b1, 4'b0001},
    '{OP_START, 8'hFF, 24'h000000, 1'b1, 4'b0001},
    '{OP_TICK,  8'h00, 24'h000000, 1'b1, 4'b0101},
    '{OP_TICK,  8'hFF, 24'hFFFFFF, 1'b1, 4'b0101},
    '{OP_TICK,  8'h5A, 24'hA5A5A5, 1'b0, 4'b0000},
    '{OP_TICK,  8'hA5, 24'h5A5A5A, 1'b0, 4'b0000}
  };

  // Phase plan: LED count, sender idle and receiver stall percentages, random requests.
  int plan_count [PLAN_LEN] = '{3, 0, 1, RANDOM_COUNT, 5, RANDOM_COUNT};
  int plan_idle  [PLAN_LEN] = '{0, 58, 0, 27, 27, 0};
  int plan_stall [PLAN_LEN] = '{0, 0, 58, 27, 27, 0};
  int plan_reqs  [PLAN_LEN] = '{100, 100, 100, 100, 0, 60};

  led_strip_frame_serializer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .led_index (led_index),
    .colour    (colour),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_bit  (data_bit),
    .bit_valid (bit_valid),
    .last      (last),
    .busy_res  (busy_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned effective_count();
    return (led_count_m > STRIP_LEDS) ? STRIP_LEDS : led_count_m;
  endfunction

  // Advance the shadow serializer by one request and return its result.
  function automatic strip_result_t step_serializer(op_t o, logic [INDEX_W-1:0] idx,
                                                    logic [COLOUR_W-1:0] col);
    strip_result_t r;
    int unsigned   eff;
    r   = '0;
    eff = effective_count();
    if (o == OP_TICK) begin
      if (phase_m != PH_IDLE) begin
        r.data_bit  = shift_m[WORD_W-1];
        r.bit_valid = 1'b1;
        shift_m     = shift_m << 1;
        if (bitcnt_m == BIT_LAST) begin
          bitcnt_m = '0;
          case (phase_m)
            PH_START: begin
              ptr_m = '0;
              if (eff > 0) begin
                phase_m = PH_LEDS;
                shift_m = HEADER_WORD | WORD_W'(store_m[0]);
              end else begin
                phase_m = PH_END;
                shift_m = END_WORD;
              end
            end
            PH_LEDS: begin
              ptr_m = ptr_m + 1'b1;
              if (ptr_m < eff) begin
                shift_m = HEADER_WORD | WORD_W'(store_m[ptr_m[INDEX_W-1:0]]);
              end else begin
                phase_m = PH_END;
                shift_m = END_WORD;
              end
            end
            default: begin
              phase_m = PH_IDLE;
              shift_m = '0;
              ptr_m   = '0;
              r.last  = 1'b1;
            end
          endcase
        end else begin
          bitcnt_m = bitcnt_m + 1'b1;
        end
      end
    end else if (phase_m == PH_IDLE) begin
      case (o)
        OP_SET: begin
          if (idx < eff) store_m[idx] = col;
        end
        OP_CLEAR: begin
          foreach (store_m[i]) store_m[i] = '0;
        end
        default: begin
          phase_m  = PH_START;
          ptr_m    = '0;
          bitcnt_m = '0;
          shift_m  = '0;
        end
      endcase
    end
    r.busy_res = (phase_m != PH_IDLE);
    return r;
  endfunction

  // Offer one request, wait for it to be taken, and queue its expected result.
  task automatic send_request(op_t o, logic [INDEX_W-1:0] idx, logic [COLOUR_W-1:0] col,
                              logic typed = 1'b0, strip_result_t typed_res = '0);
    strip_result_t pred;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid  <= 1'b1;
    op        <= o;
    led_index <= idx;
    colour    <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = step_serializer(o, idx, col);
    serial_q.push_back(typed ? typed_res : pred);
    req_total++;
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_strip_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (serial_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_led_count(logic [COUNT_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    led_count_m = value;
    settings++;
    @(posedge clk);
  endtask

  // Tick until the update in progress has sent its end frame.
  task automatic finish_update();
    while (phase_m != PH_IDLE)
      send_request(OP_TICK, INDEX_W'($urandom), COLOUR_W'($urandom));
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned eff;
    eff = effective_count();
    if (eff == 0 || $urandom_range(3) == 0) return INDEX_W'($urandom_range(255));
    return INDEX_W'($urandom_range(eff - 1));
  endfunction

  // Mostly complete updates with random colours; some noise and stray requests.
  task automatic run_traffic(int reqs);
    int   counted;
    int   r;
    op_t  o;
    logic busy;
    counted = 0;
    while (counted < reqs) begin
      busy = (phase_m != PH_IDLE);
      r    = $urandom_range(99);
      if (busy) begin
        o = (r < 92) ? OP_TICK : op_t'(OP_W'($urandom_range(2)));
      end else if (r < 55) begin
        o = OP_SET;
      end else if (r < 60) begin
        o = OP_CLEAR;
      end else if (r < 90) begin
        o = OP_START;
      end else begin
        o = OP_TICK;
      end
      send_request(o, pick_index(), COLOUR_W'($urandom));
      if (busy ? (o == OP_TICK) : (o != OP_TICK)) counted++;
    end
    finish_update();
  endtask

  // Whole update at a fixed count: set the first and last store entries and a few
  // random ones (sets beyond the count are ignored), then send the full strip.
  task automatic run_full_strip();
    int n;
    send_request(OP_SET, 8'hFF, 24'hFFFFFF);
    send_request(OP_SET, 8'h00, 24'h000000);
    for (n = 0; n < 12; n++)
      send_request(OP_SET, INDEX_W'($urandom), COLOUR_W'($urandom));
    send_request(OP_START, INDEX_W'($urandom), COLOUR_W'($urandom));
    finish_update();
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin : result_check
    strip_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (bit_valid === 1'b1) bits_seen++;
      if (last === 1'b1) updates_done++;
      if (serial_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
      end else begin
        want = serial_q.pop_front();
        if (data_bit !== want.data_bit) begin
          $error("data_bit: expected %0b, got %0b", want.data_bit, data_bit);
          errors++;
        end
        if (bit_valid !== want.bit_valid) begin
          $error("bit_valid: expected %0b, got %0b", want.bit_valid, bit_valid);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          errors++;
        end
        if (busy_res !== want.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
          errors++;
        end
      end
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall);
  end

  initial begin : stimulus
    int p;
    int cnt;
    foreach (store_m[i]) store_m[i] = '0;
    phase_m     = PH_IDLE;
    ptr_m       = '0;
    bitcnt_m    = '0;
    shift_m     = '0;
    led_count_m = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset count of zero.
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].col,
                   directed_rows[i].typed, directed_rows[i].res);
    finish_update();

    // Random phases, each at its own LED count and idling mix.
    for (p = 0; p < PLAN_LEN; p++) begin
      wait_strip_idle();
      send_idle  = plan_idle[p];
      recv_stall = plan_stall[p];
      cnt = (plan_count[p] == RANDOM_COUNT) ? $urandom_range(2, 8) : plan_count[p];
      write_led_count(COUNT_W'(cnt));
      if (plan_reqs[p] == 0) begin
        run_full_strip();
      end else begin
        send_request(OP_SET, 8'h00, 24'hFFFFFF);
        send_request(OP_SET, 8'h01, 24'h000000);
        run_traffic(plan_reqs[p]);
      end
    end

    wait_strip_idle();
    repeat (8) @(posedge clk);
    if (serial_q.size() != 0) begin
      $error("%0d results never arrived", serial_q.size());
      errors++;
    end

    $display("Run covered %0d requests, %0d serial bits and %0d complete strip updates",
             req_total, bits_seen, updates_done);
    $display("across %0d LED count settings, with %0d mismatches.", settings, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: led_strip_frame_serializer_top.f
hdl/lsfs_pkg.sv
hdl/lsfs_front.sv
hdl/lsfs_back.sv
hdl/led_strip_frame_serializer_top.sv
bench/tb.sv
